// File: sv/bwu_pkg.sv
`default_nettype none
package bwu_pkg;

  localparam int DEF_SLOT_COUNT = 8;

  localparam int KIND_W  = 3;
  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 8;
  localparam int INDEX_W = 3;

  localparam logic [DATA_W-1:0] UNBOUND_FILL = 8'h55;
  localparam logic [KIND_W-1:0] KIND_MEM_WR  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_IO_WR   = 3'd4;

  typedef enum logic [1:0] {
    OP_CHECK = 2'd0,
    OP_ADD   = 2'd1,
    OP_DEL   = 2'd2,
    OP_PASS  = 2'd3
  } op_t;

  // request word walking down the slot chain
  typedef struct packed {
    logic               vld;
    op_t                op;
    logic [KIND_W-1:0]  kind;
    logic [ADDR_W-1:0]  address;
    logic [DATA_W-1:0]  data_value;
    logic               has_value;
    logic [INDEX_W-1:0] slot_index;
    logic               done;
  } tok_t;

endpackage
`default_nettype wire

// File: sv/breakpoint_watchpoint_unit.sv
// the input word is registered, walks the slot chain one cell per cycle and
// its result is registered at the output; a new word is taken only once the
// last one has left the chain and the output register is free or being read
// reset: synchronous active-low rst_n empties all slots, disarms the skip
// and clears the active count
`default_nettype none
module breakpoint_watchpoint_unit
  import bwu_pkg::*;
#(
  parameter int SLOT_COUNT = DEF_SLOT_COUNT
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // kind, address, data_value, has_value, slot_index
  input  wire  [1:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata   // ok, skipped, active_count
);

  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  tok_t tok [0:SLOT_COUNT];
  tok_t entry_r, entry_nxt;

  logic             busy_r, busy_nxt;
  logic             skip_r, skip_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic             ok_r, ok_nxt;
  logic             skipped_r, skipped_nxt;

  logic in_acc;
  tok_t ex;

  assign in_tready = !busy_r && (!out_vld_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign tok[0]    = entry_r;
  assign ex        = tok[SLOT_COUNT];

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    bwu_cell #(.CELL_IDX(g)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_in (tok[g]),
      .tok_out(tok[g+1])
    );
  end

  always_comb begin
    entry_nxt            = entry_r;
    entry_nxt.vld        = in_acc;
    if (in_acc) begin
      entry_nxt.op         = op_t'(in_tuser);
      entry_nxt.kind       = in_tdata[2:0];
      entry_nxt.address    = in_tdata[18:3];
      entry_nxt.data_value = in_tdata[26:19];
      entry_nxt.has_value  = in_tdata[27];
      entry_nxt.slot_index = in_tdata[30:28];
      entry_nxt.done       = 1'b0;
    end

    busy_nxt    = busy_r;
    skip_nxt    = skip_r;
    cnt_nxt     = cnt_r;
    out_vld_nxt = out_vld_r && !out_tready;
    ok_nxt      = ok_r;
    skipped_nxt = skipped_r;

    if (in_acc) busy_nxt = 1'b1;

    if (ex.vld) begin
      busy_nxt    = 1'b0;
      out_vld_nxt = 1'b1;
      ok_nxt      = 1'b0;
      skipped_nxt = 1'b0;
      case (ex.op)
        OP_CHECK: begin
          if (ex.done) begin
            ok_nxt      = !skip_r;
            skipped_nxt = skip_r;
            skip_nxt    = 1'b0;
          end
        end
        OP_ADD: begin
          if (ex.done) begin
            ok_nxt   = 1'b1;
            skip_nxt = 1'b0;
            cnt_nxt  = cnt_r + CNT_W'(1);
          end
        end
        OP_DEL: begin
          if (ex.done) begin
            ok_nxt  = 1'b1;
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
        default: begin
          if (cnt_r != '0) skip_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.vld <= 1'b0;
      busy_r      <= 1'b0;
      skip_r      <= 1'b0;
      cnt_r       <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      entry_r.vld <= entry_nxt.vld;
      busy_r      <= busy_nxt;
      skip_r      <= skip_nxt;
      cnt_r       <= cnt_nxt;
      out_vld_r   <= out_vld_nxt;
    end
    entry_r.op         <= entry_nxt.op;
    entry_r.kind       <= entry_nxt.kind;
    entry_r.address    <= entry_nxt.address;
    entry_r.data_value <= entry_nxt.data_value;
    entry_r.has_value  <= entry_nxt.has_value;
    entry_r.slot_index <= entry_nxt.slot_index;
    entry_r.done       <= entry_nxt.done;
    ok_r               <= ok_nxt;
    skipped_r          <= skipped_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, 4'(cnt_r), skipped_r, ok_r};

endmodule
`default_nettype wire

// File: sv/bwu_cell.sv
`default_nettype none
module bwu_cell
  import bwu_pkg::*;
#(
  parameter int CELL_IDX = 0
) (
  input  wire  clk,
  input  wire  rst_n,
  input  tok_t tok_in,
  output tok_t tok_out
);

  logic              valid_r, valid_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              bind_r, bind_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  tok_t              tok_r, tok_nxt;

  logic live;
  logic match;
  logic idx_match;
  logic bind_new;

  always_comb begin
    live      = tok_in.vld && !tok_in.done;
    match     = valid_r && (kind_r == tok_in.kind) && (addr_r == tok_in.address) &&
                !(tok_in.has_value && bind_r && (data_r != tok_in.data_value));
    idx_match = (32'(tok_in.slot_index) == CELL_IDX);
    bind_new  = tok_in.has_value &&
                ((tok_in.kind == KIND_MEM_WR) || (tok_in.kind == KIND_IO_WR));

    valid_nxt = valid_r;
    kind_nxt  = kind_r;
    addr_nxt  = addr_r;
    bind_nxt  = bind_r;
    data_nxt  = data_r;
    tok_nxt   = tok_in;

    if (live) begin
      case (tok_in.op)
        OP_CHECK: begin
          if (match) tok_nxt.done = 1'b1;
        end
        OP_ADD: begin
          if (!valid_r) begin
            valid_nxt    = 1'b1;
            kind_nxt     = tok_in.kind;
            addr_nxt     = tok_in.address;
            bind_nxt     = bind_new;
            data_nxt     = bind_new ? tok_in.data_value : UNBOUND_FILL;
            tok_nxt.done = 1'b1;
          end
        end
        OP_DEL: begin
          if (idx_match && valid_r) begin
            valid_nxt    = 1'b0;
            tok_nxt.done = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      tok_r.vld <= tok_nxt.vld;
    end
    kind_r           <= kind_nxt;
    addr_r           <= addr_nxt;
    bind_r           <= bind_nxt;
    data_r           <= data_nxt;
    tok_r.op         <= tok_nxt.op;
    tok_r.kind       <= tok_nxt.kind;
    tok_r.address    <= tok_nxt.address;
    tok_r.data_value <= tok_nxt.data_value;
    tok_r.has_value  <= tok_nxt.has_value;
    tok_r.slot_index <= tok_nxt.slot_index;
    tok_r.done       <= tok_nxt.done;
  end

  assign tok_out = tok_r;

endmodule
`default_nettype wire

// File: tb/tb.sv
`default_nettype none
module tb;
  import bwu_pkg::*;

  localparam int SLOTS = DEF_SLOT_COUNT;
  localparam int RANDOM_WORDS = 1875;
  localparam int HOLD_CYCLES = 300;

  localparam logic [KIND_W-1:0] KIND_EXEC   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MEM_RD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_IO_RD  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RSVD7  = 3'd7;

  typedef struct {
    op_t                op;
    logic [KIND_W-1:0]  kind;
    logic [ADDR_W-1:0]  address;
    logic [DATA_W-1:0]  data_value;
    logic               has_value;
    logic [INDEX_W-1:0] slot_index;
  } access_req_t;

  typedef struct {
    logic       ok;
    logic       skipped;
    logic [3:0] active_count;
  } response_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;

  breakpoint_watchpoint_unit #(.SLOT_COUNT(SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the monitor table
  logic              tbl_valid [SLOTS];
  logic [KIND_W-1:0] tbl_kind  [SLOTS];
  logic [ADDR_W-1:0] tbl_addr  [SLOTS];
  logic              tbl_bind  [SLOTS];
  logic [DATA_W-1:0] tbl_data  [SLOTS];
  logic              skip_pending = 1'b0;
  logic [3:0]        live_slots = '0;

  access_req_t pending_reqs[$];
  response_t   expected_responses[$];
  int          total_words = 0;
  int          accepted_words = 0;
  int          error_count = 0;
  int          n_check = 0, n_hit = 0, n_swallowed = 0;
  int          n_add = 0, n_full = 0, n_del = 0, n_pass = 0;
  int          held_cycles = 0;
  logic        hold_off = 1'b0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_kind[i]  = '0;
      tbl_addr[i]  = '0;
      tbl_bind[i]  = 1'b0;
      tbl_data[i]  = '0;
    end
  end

  function automatic response_t predict_response(access_req_t r);
    response_t rsp;
    logic      bind_flag;
    rsp.ok = 1'b0;
    rsp.skipped = 1'b0;
    case (r.op)
      OP_CHECK: begin
        n_check++;
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i] && tbl_kind[i] == r.kind && tbl_addr[i] == r.address &&
              !(r.has_value && tbl_bind[i] && tbl_data[i] != r.data_value)) begin
            if (skip_pending) begin
              skip_pending = 1'b0;
              rsp.skipped = 1'b1;
              n_swallowed++;
            end else begin
              rsp.ok = 1'b1;
              n_hit++;
            end
            break;
          end
        end
      end
      OP_ADD: begin
        n_add++;
        for (int i = 0; i < SLOTS; i++) begin
          if (!tbl_valid[i]) begin
            bind_flag = r.has_value && (r.kind == KIND_MEM_WR || r.kind == KIND_IO_WR);
            tbl_valid[i] = 1'b1;
            tbl_kind[i]  = r.kind;
            tbl_addr[i]  = r.address;
            tbl_bind[i]  = bind_flag;
            tbl_data[i]  = bind_flag ? r.data_value : UNBOUND_FILL;
            skip_pending = 1'b0;
            live_slots++;
            rsp.ok = 1'b1;
            break;
          end
        end
        if (!rsp.ok) n_full++;
      end
      OP_DEL: begin
        n_del++;
        if (int'(r.slot_index) < SLOTS && tbl_valid[r.slot_index]) begin
          tbl_valid[r.slot_index] = 1'b0;
          live_slots--;
          rsp.ok = 1'b1;
        end
      end
      default: begin
        n_pass++;
        if (live_slots != 0) skip_pending = 1'b1;
      end
    endcase
    rsp.active_count = live_slots;
    return rsp;
  endfunction

  function automatic int idle_phase();
    if (total_words == 0) return 0;
    return (accepted_words * 4) / total_words;
  endfunction

  task automatic queue_req(op_t op, logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] address,
                           logic [DATA_W-1:0] data_value, logic has_value,
                           logic [INDEX_W-1:0] slot_index);
    access_req_t r;
    r.op = op;
    r.kind = kind;
    r.address = address;
    r.data_value = data_value;
    r.has_value = has_value;
    r.slot_index = slot_index;
    pending_reqs.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin : drive
    logic fire;
    logic send;
    int   pct;
    fire = in_tvalid && in_tready;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        expected_responses.push_back(predict_response(pending_reqs[0]));
        void'(pending_reqs.pop_front());
        accepted_words++;
      end
      if (!(in_tvalid && !fire)) begin
        pct = (idle_phase() == 1) ? 83 : (idle_phase() == 3) ? 35 : 0;
        send = pending_reqs.size() != 0 && $urandom_range(99) >= pct;
        in_tvalid <= send;
        if (send) begin
          in_tdata <= {1'b0, pending_reqs[0].slot_index, pending_reqs[0].has_value,
                       pending_reqs[0].data_value, pending_reqs[0].address,
                       pending_reqs[0].kind};
          in_tuser <= pending_reqs[0].op;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : sink
    response_t got;
    response_t want;
    int        pct;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.ok = out_tdata[0];
        got.skipped = out_tdata[1];
        got.active_count = out_tdata[5:2];
        if (expected_responses.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected result word ok=%0b skipped=%0b active=%0d",
                     got.ok, got.skipped, got.active_count);
        end else begin
          want = expected_responses.pop_front();
          if (got.ok != want.ok || got.skipped != want.skipped ||
              got.active_count != want.active_count) begin
            error_count++;
            if (error_count <= 10)
              $display({"mismatch: expected ok=%0b skipped=%0b active=%0d, ",
                        "got ok=%0b skipped=%0b active=%0d"},
                       want.ok, want.skipped, want.active_count,
                       got.ok, got.skipped, got.active_count);
          end
        end
      end
      pct = (idle_phase() == 2) ? 83 : (idle_phase() == 3) ? 35 : 0;
      out_tready <= !hold_off && $urandom_range(99) >= pct;
    end
  end

  // long receiver hold-off while words keep coming
  initial begin
    while (accepted_words < 150) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) begin
      @(posedge clk);
      held_cycles++;
    end
    hold_off <= 1'b0;
  end

  initial begin
    #3200000;
    $display("breakpoint_watchpoint_unit regression: fail");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] addr_pool [4];
    logic [DATA_W-1:0] data_pool [3];
    access_req_t       r;
    int                sel;

    // empty table, free slot, then fill a few slots
    queue_req(OP_PASS,  KIND_EXEC,   16'h0000, 8'h00, 1'b0, 3'd0);
    queue_req(OP_CHECK, KIND_EXEC,   16'h0000, 8'h00, 1'b0, 3'd0);
    queue_req(OP_DEL,   KIND_EXEC,   16'h0000, 8'h00, 1'b0, 3'd3);
    queue_req(OP_ADD,   KIND_EXEC,   16'h0000, 8'h00, 1'b0, 3'd0);
    queue_req(OP_ADD,   KIND_MEM_WR, 16'hFFFF, 8'hA5, 1'b1, 3'd7);
    queue_req(OP_ADD,   KIND_MEM_RD, 16'h1234, 8'h12, 1'b1, 3'd0);
    queue_req(OP_ADD,   KIND_RSVD7,  16'h8000, 8'hFF, 1'b0, 3'd0);
    // bound byte, missing byte, unbound read, odd kind
    queue_req(OP_CHECK, KIND_MEM_WR, 16'hFFFF, 8'hA5, 1'b1, 3'd0);
    queue_req(OP_CHECK, KIND_MEM_WR, 16'hFFFF, 8'h5A, 1'b1, 3'd0);
    queue_req(OP_CHECK, KIND_MEM_WR, 16'hFFFF, 8'h00, 1'b0, 3'd0);
    queue_req(OP_CHECK, KIND_MEM_RD, 16'h1234, 8'h99, 1'b1, 3'd0);
    queue_req(OP_CHECK, KIND_RSVD7,  16'h8000, 8'hFF, 1'b1, 3'd5);
    // skip survives a miss, swallowed by the next hit
    queue_req(OP_PASS,  KIND_EXEC,   16'h0000, 8'h00, 1'b0, 3'd0);
    queue_req(OP_CHECK, KIND_EXEC,   16'h0001, 8'h00, 1'b0, 3'd0);
    queue_req(OP_CHECK, KIND_EXEC,   16'h0000, 8'h00, 1'b0, 3'd0);
    // add disarms the skip
    queue_req(OP_PASS,  KIND_EXEC,   16'h0000, 8'h00, 1'b0, 3'd0);
    queue_req(OP_ADD,   KIND_IO_WR,  16'hABCD, 8'hFF, 1'b1, 3'd0);
    queue_req(OP_CHECK, KIND_IO_WR,  16'hABCD, 8'hFF, 1'b1, 3'd0);
    // full table keeps the skip armed
    queue_req(OP_ADD,   KIND_IO_RD,  16'h00FF, 8'h00, 1'b0, 3'd0);
    queue_req(OP_ADD,   KIND_IO_WR,  16'hFF00, 8'h00, 1'b1, 3'd0);
    queue_req(OP_ADD,   KIND_EXEC,   16'h5555, 8'hAA, 1'b1, 3'd0);
    queue_req(OP_PASS,  KIND_EXEC,   16'h0000, 8'h00, 1'b0, 3'd0);
    queue_req(OP_ADD,   KIND_EXEC,   16'h7777, 8'h00, 1'b0, 3'd0);
    queue_req(OP_CHECK, KIND_EXEC,   16'h0000, 8'h00, 1'b0, 3'd0);
    queue_req(OP_DEL,   KIND_EXEC,   16'h0000, 8'h00, 1'b0, 3'd7);

    addr_pool[0] = 16'h0000;
    addr_pool[1] = 16'hFFFF;
    addr_pool[2] = 16'($urandom);
    addr_pool[3] = 16'($urandom);
    data_pool[0] = 8'h00;
    data_pool[1] = 8'hFF;
    data_pool[2] = UNBOUND_FILL;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 200 == 199) addr_pool[$urandom_range(3)] = 16'($urandom);
      sel = $urandom_range(99);
      r.op = (sel < 50) ? OP_CHECK : (sel < 64) ? OP_ADD : (sel < 86) ? OP_DEL : OP_PASS;
      r.kind = ($urandom_range(9) < 8) ? 3'($urandom_range(4)) : 3'($urandom_range(7));
      r.address = ($urandom_range(6) < 6) ? addr_pool[$urandom_range(3)] : 16'($urandom);
      r.data_value = ($urandom_range(3) < 3) ? data_pool[$urandom_range(2)] : 8'($urandom);
      r.has_value = 1'($urandom_range(1));
      r.slot_index = 3'($urandom_range(7));
      pending_reqs.push_back(r);
    end
    total_words = pending_reqs.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (4 * (SLOTS + 2)) @(posedge clk);

    $display("covered %0d words: %0d checks (%0d hits, %0d swallowed), %0d adds",
             accepted_words, n_check, n_hit, n_swallowed, n_add);
    $display("with %0d on a full table, %0d deletes, %0d passes, a hold-off of %0d cycles",
             n_full, n_del, n_pass, held_cycles);
    $display("%0d errors", error_count);
    if (error_count == 0) begin
      $display("breakpoint_watchpoint_unit regression: pass");
    end else begin
      $display("breakpoint_watchpoint_unit regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
